// ----- design/riffp_pkg.sv -----
// Shared types and constants for the RIFF/WAVE smpl loop probe.
// No dependencies; every other design file imports this package.
package riffp_pkg;

    // Four-character chunk tags, little-endian as they arrive on the wire.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_SMPL = 32'h6C70_6D73;

    // Status codes carried on the result word.
    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER      = 3'd1;
    localparam logic [2:0] ST_CHUNK_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_SMPL_SHORT      = 3'd3;
    localparam logic [2:0] ST_LOOP_MISSING    = 3'd4;
    localparam logic [2:0] ST_END_BEFORE_START = 3'd5;

    // File layout constants.
    localparam int unsigned FILE_HDR_BYTES = 12;
    localparam int unsigned CHUNK_HDR_BYTES = 8;
    localparam int unsigned SMPL_MIN_SIZE  = 36;
    localparam int unsigned SMPL_LOOP_SIZE = 60;

    // Byte offsets inside the smpl body and the chunk header.
    localparam logic [5:0] OFF_TAG_LAST   = 6'd3;
    localparam logic [5:0] OFF_HDR_LAST   = 6'd7;
    localparam logic [5:0] OFF_COUNT_LO   = 6'd28;
    localparam logic [5:0] OFF_COUNT_HI   = 6'd31;
    localparam logic [5:0] OFF_START_LO   = 6'd44;
    localparam logic [5:0] OFF_START_HI   = 6'd47;
    localparam logic [5:0] OFF_END_LO     = 6'd48;
    localparam logic [5:0] OFF_END_HI     = 6'd51;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CHUNKHDR,
        PH_SKIP,
        PH_SMPL
    } phase_t;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] payload_length;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic        loop_found;
        logic [2:0]  status_code;
        logic [31:0] loop_start;
        logic [31:0] loop_end;
    } result_t;

    // Shift a byte into the top of a little-endian accumulator.
    function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] b);
        return {b, acc[31:8]};
    endfunction

endpackage

// ----- design/riffp_in_stage.sv -----
// Input register for the byte stream: one word deep, refilled in the same cycle it drains.
// Depends on riffp_pkg for the input word type.
module riffp_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  riffp_pkg::in_word_t in_word,
    input  logic               take,
    output logic               word_valid,
    output riffp_pkg::in_word_t word
);
    import riffp_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_word_t word_reg;

    // The register may load whenever it is empty or its word is consumed now.
    assign in_ready   = !vld_reg || take;
    assign word_valid = vld_reg;
    assign word       = word_reg;

    always_comb begin
        vld_next = vld_reg;
        if (in_valid && in_ready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload register carries no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= in_word;
        end
    end

    // A held word that is not consumed must stay put.
    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg && !take |=> vld_reg && $stable(word_reg))
        else $error("input word changed while waiting");

endmodule

// ----- design/riffp_core.sv -----
// Byte-at-a-time RIFF/WAVE chunk walker that latches the first smpl loop outcome.
// Depends on riffp_pkg for phases, tags, status codes and word types.
module riffp_core #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                word_valid,
    input  riffp_pkg::in_word_t word,
    input  logic                out_free,
    output logic                take,
    output logic                res_valid,
    output riffp_pkg::result_t  result
);
    import riffp_pkg::*;

    // Total length width, offset register width and arithmetic width.
    localparam int unsigned TW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam int unsigned OW = TW + 2;
    localparam int unsigned AW = (LENGTH_BITS + 1 > 35) ? LENGTH_BITS + 1 : 35;
    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    phase_t                 phase_reg, phase_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [31:0]            tag_reg, tag_next;
    logic [31:0]            size_reg, size_next;
    logic [OW-1:0]          next_off_reg, next_off_next;
    logic [5:0]             shift_reg, shift_next;
    logic [31:0]            count_reg, count_next;
    logic [31:0]            start_reg, start_next;
    logic [31:0]            end_reg, end_next;
    logic                   latched_reg, latched_next;
    logic [2:0]             status_reg, status_next;
    logic                   found_reg, found_next;

    logic          first;
    logic [TW-1:0] tot;
    logic [AW-1:0] pos_a, tot_a, off_a, body_a, size_a, walk_a;
    logic          skip_hit;
    phase_t        phase_eff;
    logic [5:0]    sh_eff;

    // A word is consumed unless it closes a payload and the result slot is full.
    assign take      = word_valid && (!word.last_byte || out_free);
    assign res_valid = take && word.last_byte;

    assign first    = (pos_reg == '0);
    assign tot      = first ? word.payload_length[TW-1:0] : total_reg;
    assign pos_a    = AW'(pos_reg);
    assign tot_a    = AW'(tot);
    assign off_a    = AW'(next_off_reg);
    assign body_a   = off_a + AW'(CHUNK_HDR_BYTES);
    assign skip_hit = (phase_reg == PH_SKIP) && (pos_a == off_a);
    assign phase_eff = skip_hit ? PH_CHUNKHDR : phase_reg;
    assign sh_eff    = skip_hit ? 6'd0 : shift_reg;

    // Next state of the parser for the word being consumed.
    always_comb begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        total_next    = total_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        next_off_next = next_off_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        latched_next  = latched_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        size_a        = '0;
        walk_a        = '0;
        result        = '0;

        if (take) begin
            total_next = tot;
            // A declared length shorter than the file header is rejected at once.
            if (first && (tot < TW'(FILE_HDR_BYTES))) begin
                latched_next = 1'b1;
                status_next  = ST_BAD_HEADER;
                found_next   = 1'b0;
            end

            if (!latched_next && (pos_a < tot_a)) begin
                case (phase_eff)
                    PH_HEADER: begin
                        tag_next = shift_in(tag_reg, word.data_byte);
                        if ((pos_reg == LENGTH_BITS'(3)) && (tag_next != TAG_RIFF)) begin
                            latched_next = 1'b1;
                            status_next  = ST_BAD_HEADER;
                        end else if (pos_reg == LENGTH_BITS'(11)) begin
                            if (tag_next != TAG_WAVE) begin
                                latched_next = 1'b1;
                                status_next  = ST_BAD_HEADER;
                            end else begin
                                next_off_next = OW'(FILE_HDR_BYTES);
                                phase_next    = PH_SKIP;
                                // Stop if no chunk header fits after the file header.
                                if (tot_a < AW'(FILE_HDR_BYTES + CHUNK_HDR_BYTES)) begin
                                    latched_next = 1'b1;
                                    status_next  = ST_OK;
                                end
                            end
                        end
                    end
                    PH_CHUNKHDR: begin
                        phase_next = PH_CHUNKHDR;
                        if (sh_eff <= OFF_TAG_LAST) begin
                            tag_next = shift_in(tag_reg, word.data_byte);
                        end else begin
                            size_next = shift_in(size_reg, word.data_byte);
                        end
                        size_a = AW'(size_next);
                        walk_a = body_a + size_a + AW'(size_next[0]);
                        if (sh_eff == OFF_HDR_LAST) begin
                            shift_next = sh_eff;
                            if (body_a + size_a > tot_a) begin
                                latched_next = 1'b1;
                                status_next  = ST_CHUNK_OVERRUN;
                            end else if (tag_next == TAG_SMPL) begin
                                if (size_next < 32'(SMPL_MIN_SIZE)) begin
                                    latched_next = 1'b1;
                                    status_next  = ST_SMPL_SHORT;
                                end else begin
                                    phase_next = PH_SMPL;
                                    shift_next = 6'd0;
                                end
                            end else begin
                                next_off_next = OW'(walk_a);
                                phase_next    = PH_SKIP;
                                // Stop if the next chunk header would not fit.
                                if (walk_a + AW'(CHUNK_HDR_BYTES) > tot_a) begin
                                    latched_next = 1'b1;
                                    status_next  = ST_OK;
                                end
                            end
                        end else begin
                            shift_next = sh_eff + 6'd1;
                        end
                    end
                    PH_SMPL: begin
                        // Gather the loop count and the first loop's frame bounds.
                        if (sh_eff >= OFF_COUNT_LO && sh_eff <= OFF_COUNT_HI) begin
                            count_next = shift_in(count_reg, word.data_byte);
                        end else if (sh_eff >= OFF_START_LO && sh_eff <= OFF_START_HI) begin
                            start_next = shift_in(start_reg, word.data_byte);
                        end else if (sh_eff >= OFF_END_LO && sh_eff <= OFF_END_HI) begin
                            end_next = shift_in(end_reg, word.data_byte);
                        end
                        if (sh_eff == OFF_COUNT_HI) begin
                            if (count_next == '0) begin
                                latched_next = 1'b1;
                                status_next  = ST_OK;
                            end else if (size_reg < 32'(SMPL_LOOP_SIZE)) begin
                                latched_next = 1'b1;
                                status_next  = ST_LOOP_MISSING;
                            end
                        end else if (sh_eff == OFF_END_HI) begin
                            latched_next = 1'b1;
                            if (end_next < start_reg) begin
                                status_next = ST_END_BEFORE_START;
                            end else begin
                                status_next = ST_OK;
                                found_next  = 1'b1;
                            end
                        end
                        shift_next = sh_eff + 6'd1;
                    end
                    default: begin
                        // Skipping a chunk body: nothing to gather.
                    end
                endcase
            end

            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + LENGTH_BITS'(1);
            end

            // The last byte closes the payload: report and rearm.
            if (word.last_byte) begin
                if (!latched_next) begin
                    status_next = (phase_next == PH_HEADER) ? ST_BAD_HEADER : ST_OK;
                    found_next  = 1'b0;
                end
                result.loop_found  = found_next;
                result.status_code = status_next;
                result.loop_start  = found_next ? start_next : 32'd0;
                result.loop_end    = found_next ? end_next : 32'd0;

                pos_next      = '0;
                phase_next    = PH_HEADER;
                total_next    = '0;
                tag_next      = '0;
                size_next     = '0;
                next_off_next = OW'(FILE_HDR_BYTES);
                shift_next    = '0;
                count_next    = '0;
                start_next    = '0;
                end_next      = '0;
                latched_next  = 1'b0;
                status_next   = ST_OK;
                found_next    = 1'b0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            phase_reg    <= PH_HEADER;
            total_reg    <= '0;
            tag_reg      <= '0;
            size_reg     <= '0;
            next_off_reg <= OW'(FILE_HDR_BYTES);
            shift_reg    <= '0;
            count_reg    <= '0;
            start_reg    <= '0;
            end_reg      <= '0;
            latched_reg  <= 1'b0;
            status_reg   <= ST_OK;
            found_reg    <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            total_reg    <= total_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            next_off_reg <= next_off_next;
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            start_reg    <= start_next;
            end_reg      <= end_next;
            latched_reg  <= latched_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
        end
    end

    // A closed payload leaves the parser rearmed.
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (pos_reg == '0) && !latched_reg && (phase_reg == PH_HEADER))
        else $error("parser not rearmed after last byte");

    // Status and found flag only move once an outcome is latched.
    a_unlatched_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !latched_reg |-> (status_reg == ST_OK) && !found_reg)
        else $error("outcome bits set without latch");

    // A found loop always reports success.
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> latched_reg && (status_reg == ST_OK))
        else $error("found flag with error status");

    // The smpl body offset never runs more than one past the end frame field.
    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_reg <= OFF_END_HI + 6'd1)
        else $error("body offset out of range");

endmodule

// ----- design/riffp_out_stage.sv -----
// Result register: holds one result word until the downstream side takes it.
// Depends on riffp_pkg for the result type.
module riffp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  riffp_pkg::result_t result,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output riffp_pkg::result_t out_word
);
    import riffp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // The slot can take a new result when empty or drained this cycle.
    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_word  = res_reg;

    always_comb begin
        vld_next = vld_reg;
        if (res_valid) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= result;
        end
    end

    // The core never loads a result over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result overwritten before delivery");

endmodule

// ----- design/riff_smpl_loop_probe_top.sv -----
// RIFF/WAVE smpl loop probe: accepts one payload byte per cycle, sustained.
// A result appears on m_ once its last byte has passed through the input register and the
// chunk walker's update has filled the result register; a waiting result holds that byte back.
// Input stalls only while a finished result waits and the next last byte arrives.
// Reset (aresetn low, synchronous) empties both registers and rearms the parser.
module riff_smpl_loop_probe_top #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [31:0] s_payload_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_loop_found,
    output logic [2:0]  m_status_code,
    output logic [31:0] m_loop_start,
    output logic [31:0] m_loop_end
);
    import riffp_pkg::*;

    in_word_t in_word;
    in_word_t word;
    logic     word_valid;
    logic     take;
    logic     res_valid;
    logic     out_free;
    result_t  result;
    result_t  out_word;

    // Gather the input ports into one word.
    assign in_word.data_byte      = s_data_byte;
    assign in_word.last_byte      = s_last_byte;
    assign in_word.payload_length = s_payload_length;

    riffp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_word    (in_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    riffp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word       (word),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .result     (result)
    );

    riffp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .result    (result),
        .out_free  (out_free),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    // Spread the result word onto the output ports.
    assign m_loop_found  = out_word.loop_found;
    assign m_status_code = out_word.status_code;
    assign m_loop_start  = out_word.loop_start;
    assign m_loop_end    = out_word.loop_end;

endmodule

// ----- dv/riff_smpl_loop_probe_checker.sv -----
`timescale 1ns / 100ps
// Checker for the RIFF/WAVE smpl loop probe: watches both channels, predicts each result word
// and compares it field by field. Depends on riffp_pkg for tags, status codes and phases.
module riff_smpl_loop_probe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [31:0] s_payload_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_loop_found,
    input  logic [2:0]  m_status_code,
    input  logic [31:0] m_loop_start,
    input  logic [31:0] m_loop_end,
    output int          fail_count,
    output int          reports_due
);
    import riffp_pkg::*;

    localparam longint unsigned POS_MAX = 64'h0000_0000_FFFF_FFFF;

    // Parser state mirrored from the block's behaviour.
    longint unsigned byte_pos;
    longint unsigned decl_len;
    longint unsigned next_hdr;
    phase_t          walk_phase;
    logic [31:0]     tag_acc;
    logic [31:0]     size_acc;
    logic [31:0]     count_acc;
    logic [31:0]     start_acc;
    logic [31:0]     end_acc;
    int unsigned     body_idx;
    bit              settled;
    bit              loop_seen;
    logic [2:0]      held_status;

    result_t due_reports[$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    // Return the parser to its state at the start of a payload.
    task automatic rearm_parser();
        byte_pos    = 0;
        decl_len    = 0;
        next_hdr    = FILE_HDR_BYTES;
        walk_phase  = PH_HEADER;
        tag_acc     = '0;
        size_acc    = '0;
        count_acc   = '0;
        start_acc   = '0;
        end_acc     = '0;
        body_idx    = 0;
        settled     = 1'b0;
        loop_seen   = 1'b0;
        held_status = ST_OK;
    endtask

    task automatic latch_outcome(input logic [2:0] code, input bit hit);
        settled     = 1'b1;
        held_status = code;
        loop_seen   = hit;
    endtask

    // Once a chunk has been passed, the walk stops unless another chunk header still fits.
    task automatic end_walk_if_full();
        if (next_hdr > decl_len || decl_len - next_hdr < CHUNK_HDR_BYTES) begin
            latch_outcome(ST_OK, 1'b0);
        end
    endtask

    // Advance the parser by one payload byte; a word marked last queues the expected result.
    task automatic probe_byte(input logic [7:0] b, input logic is_last, input logic [31:0] len);
        longint unsigned body_start;
        result_t         report;
        if (byte_pos == 0) begin
            decl_len = len;
            if (decl_len < FILE_HDR_BYTES) begin
                latch_outcome(ST_BAD_HEADER, 1'b0);
            end
        end
        if (!settled && byte_pos < decl_len) begin
            if (walk_phase == PH_HEADER) begin
                tag_acc = {b, tag_acc[31:8]};
                if (byte_pos == OFF_TAG_LAST && tag_acc != TAG_RIFF) begin
                    latch_outcome(ST_BAD_HEADER, 1'b0);
                end else if (byte_pos == FILE_HDR_BYTES - 1) begin
                    if (tag_acc != TAG_WAVE) begin
                        latch_outcome(ST_BAD_HEADER, 1'b0);
                    end else begin
                        next_hdr   = FILE_HDR_BYTES;
                        walk_phase = PH_SKIP;
                        end_walk_if_full();
                    end
                end
            end else begin
                if (walk_phase == PH_SKIP && byte_pos == next_hdr) begin
                    walk_phase = PH_CHUNKHDR;
                    body_idx   = 0;
                end
                if (walk_phase == PH_CHUNKHDR) begin
                    // Tag in the first four bytes, little-endian size in the next four.
                    if (body_idx <= OFF_TAG_LAST) begin
                        tag_acc = {b, tag_acc[31:8]};
                    end else begin
                        size_acc = {b, size_acc[31:8]};
                    end
                    if (body_idx == OFF_HDR_LAST) begin
                        body_start = next_hdr + CHUNK_HDR_BYTES;
                        if (size_acc > decl_len - body_start) begin
                            latch_outcome(ST_CHUNK_OVERRUN, 1'b0);
                        end else if (tag_acc == TAG_SMPL) begin
                            if (size_acc < SMPL_MIN_SIZE) begin
                                latch_outcome(ST_SMPL_SHORT, 1'b0);
                            end else begin
                                walk_phase = PH_SMPL;
                                body_idx   = 0;
                            end
                        end else begin
                            // Bodies are padded to an even length.
                            next_hdr   = body_start + size_acc + size_acc[0];
                            walk_phase = PH_SKIP;
                            end_walk_if_full();
                        end
                    end else begin
                        body_idx++;
                    end
                end else if (walk_phase == PH_SMPL) begin
                    if (body_idx >= OFF_COUNT_LO && body_idx <= OFF_COUNT_HI) begin
                        count_acc = {b, count_acc[31:8]};
                    end else if (body_idx >= OFF_START_LO && body_idx <= OFF_START_HI) begin
                        start_acc = {b, start_acc[31:8]};
                    end else if (body_idx >= OFF_END_LO && body_idx <= OFF_END_HI) begin
                        end_acc = {b, end_acc[31:8]};
                    end
                    if (body_idx == OFF_COUNT_HI) begin
                        if (count_acc == 0) begin
                            latch_outcome(ST_OK, 1'b0);
                        end else if (size_acc < SMPL_LOOP_SIZE) begin
                            latch_outcome(ST_LOOP_MISSING, 1'b0);
                        end
                    end else if (body_idx == OFF_END_HI) begin
                        if (end_acc < start_acc) begin
                            latch_outcome(ST_END_BEFORE_START, 1'b0);
                        end else begin
                            latch_outcome(ST_OK, 1'b1);
                        end
                    end
                    body_idx++;
                end
            end
        end
        if (byte_pos < POS_MAX) begin
            byte_pos++;
        end
        if (is_last) begin
            // An end inside the file header is a bad header; anywhere else it means no loop.
            if (!settled) begin
                latch_outcome((walk_phase == PH_HEADER) ? ST_BAD_HEADER : ST_OK, 1'b0);
            end
            report.loop_found  = loop_seen;
            report.status_code = held_status;
            report.loop_start  = loop_seen ? start_acc : '0;
            report.loop_end    = loop_seen ? end_acc : '0;
            due_reports.push_back(report);
            rearm_parser();
        end
    endtask

    function automatic void match_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Result words are checked before the input word of the same edge is predicted.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            rearm_parser();
            due_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    $display("%0t: result word with none expected, got found=%0d status=%0d %0h %0h",
                             $time, m_loop_found, m_status_code, m_loop_start, m_loop_end);
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    match_field("loop_found", want.loop_found, m_loop_found);
                    match_field("status_code", want.status_code, m_status_code);
                    match_field("loop_start", want.loop_start, m_loop_start);
                    match_field("loop_end", want.loop_end, m_loop_end);
                end
            end
            if (s_valid && s_ready) begin
                probe_byte(s_data_byte, s_last_byte, s_payload_length);
            end
        end
        reports_due <= due_reports.size();
    end

endmodule

// ----- dv/riff_smpl_loop_probe_top_tb.sv -----
`timescale 1ns / 100ps
// Top of the smpl loop probe testbench: clock, reset, payload stimulus and the verdict.
// Depends on riffp_pkg, riff_smpl_loop_probe_top and riff_smpl_loop_probe_checker.
module riff_smpl_loop_probe_top_tb;
    import riffp_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic [31:0] s_payload_length;
    logic        m_valid;
    logic        m_ready;
    logic        m_loop_found;
    logic [2:0]  m_status_code;
    logic [31:0] m_loop_start;
    logic [31:0] m_loop_end;
    int          fail_count;
    int          reports_due;

    int unsigned valid_idle_pct = 6;
    int unsigned ready_idle_pct = 51;
    int unsigned words_sent     = 0;
    int unsigned files_sent     = 0;
    int          quiet_cycles   = 0;
    logic [7:0]  file_bytes[$];

    riff_smpl_loop_probe_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .s_payload_length(s_payload_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_loop_found    (m_loop_found),
        .m_status_code   (m_status_code),
        .m_loop_start    (m_loop_start),
        .m_loop_end      (m_loop_end)
    );

    riff_smpl_loop_probe_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .s_payload_length(s_payload_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_loop_found    (m_loop_found),
        .m_status_code   (m_status_code),
        .m_loop_start    (m_loop_start),
        .m_loop_end      (m_loop_end),
        .fail_count      (fail_count),
        .reports_due     (reports_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The receiver stalls at random, at the rate of the current leg.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= ready_idle_pct);
        end
    end

    // Give up when no word has moved on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_word(input logic [31:0] w);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[31:24]);
    endtask

    task automatic put_noise(input int unsigned n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    // RIFF tag, a size field the probe never reads, and the form tag.
    task automatic put_head(input logic [31:0] riff_tag, input logic [31:0] form_tag);
        put_word(riff_tag);
        put_word($urandom);
        put_word(form_tag);
    endtask

    // A chunk whose declared size need not match the body actually written.
    task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size,
                             input int unsigned body_len);
        put_word(tag);
        put_word(size);
        put_noise(body_len + body_len % 2);
    endtask

    // A smpl chunk with the loop count and first loop placed at their body offsets.
    task automatic put_smpl(input logic [31:0] size, input logic [31:0] count,
                            input logic [31:0] first, input logic [31:0] last_frame);
        logic [7:0] b;
        put_word(TAG_SMPL);
        put_word(size);
        for (int k = 0; k < size + size[0]; k++) begin
            b = 8'($urandom);
            if (k >= OFF_COUNT_LO && k <= OFF_COUNT_HI) begin
                b = count[8 * (k - OFF_COUNT_LO) +: 8];
            end else if (k >= OFF_START_LO && k <= OFF_START_HI) begin
                b = first[8 * (k - OFF_START_LO) +: 8];
            end else if (k >= OFF_END_LO && k <= OFF_END_HI) begin
                b = last_frame[8 * (k - OFF_END_LO) +: 8];
            end
            file_bytes.push_back(b);
        end
    endtask

    // Send the built payload, one word per handshake, with random gaps before each word.
    task automatic send_file(input logic [31:0] declared);
        int unsigned n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < valid_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid          <= 1'b1;
            s_data_byte      <= file_bytes[i];
            s_last_byte      <= (i == n - 1);
            s_payload_length <= (i == 0) ? declared : $urandom;
            do @(posedge aclk); while (!s_ready);
        end
        words_sent += n;
        files_sent++;
        file_bytes.delete();
    endtask

    // Mostly well-formed files with random content; the rest are broken or truncated.
    task automatic random_file();
        int unsigned shape;
        int unsigned len;
        int unsigned pick;
        logic [31:0] size;
        logic [31:0] count;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] declared;
        shape = $urandom_range(99);
        if (shape < 4) begin
            put_noise($urandom_range(1, 14));
            declared = $urandom_range(0, 11);
        end else begin
            put_head((shape < 7) ? $urandom : TAG_RIFF,
                     (shape >= 7 && shape < 10) ? $urandom : TAG_WAVE);
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(99) < 6) begin
                    put_chunk($urandom, $urandom | 32'h8000_0000, $urandom_range(0, 8));
                end else begin
                    len = $urandom_range(0, 13);
                    put_chunk($urandom, len, len);
                end
            end
            if ($urandom_range(99) < 80) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    size = $urandom_range(SMPL_LOOP_SIZE, SMPL_LOOP_SIZE + 12);
                end else if (pick < 85) begin
                    size = $urandom_range(SMPL_MIN_SIZE, SMPL_LOOP_SIZE - 1);
                end else begin
                    size = $urandom_range(0, SMPL_MIN_SIZE - 1);
                end
                count = ($urandom_range(99) < 12) ? 32'd0 : ($urandom_range(1) ? 32'd1 : $urandom);
                lo = $urandom;
                hi = $urandom;
                if ($urandom_range(99) < 10) begin
                    hi = lo;
                end else if ($urandom_range(99) < 75 && hi < lo) begin
                    hi = lo ^ hi;
                    lo = lo ^ hi;
                    hi = lo ^ hi;
                end
                put_smpl(size, count, lo, hi);
                put_noise($urandom_range(0, 12));
            end else begin
                put_noise($urandom_range(0, CHUNK_HDR_BYTES - 1));
            end
            declared = file_bytes.size();
            pick = $urandom_range(99);
            if (pick < 8) begin
                declared = $urandom_range(FILE_HDR_BYTES, file_bytes.size());
            end else if (pick < 14) begin
                declared = file_bytes.size() + $urandom_range(1, 40);
            end else if (pick < 17) begin
                declared = $urandom;
            end else if (pick < 22) begin
                file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
            end
        end
        send_file(declared);
    endtask

    initial begin
        int unsigned mark;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data_byte      = '0;
        s_last_byte      = 1'b0;
        s_payload_length = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Well-formed file whose loop starts and ends on the same frame.
        put_head(TAG_RIFF, TAG_WAVE);
        put_smpl(SMPL_LOOP_SIZE, 1, 0, 0);
        send_file(file_bytes.size());
        // Odd-sized chunk ahead of smpl, so padding is skipped; widest loop.
        put_head(TAG_RIFF, TAG_WAVE);
        put_chunk(32'h2074_6D66, 5, 5);
        put_smpl(SMPL_LOOP_SIZE + 1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_file(file_bytes.size());
        // End frame before start frame.
        put_head(TAG_RIFF, TAG_WAVE);
        put_smpl(SMPL_LOOP_SIZE + 4, 2, 32'hFFFF_FFFF, 32'h0);
        send_file(file_bytes.size());
        // A smpl chunk with no loops is not an error.
        put_head(TAG_RIFF, TAG_WAVE);
        put_smpl(SMPL_LOOP_SIZE, 0, 1, 2);
        send_file(file_bytes.size());
        // Loops counted but the chunk is too small to hold one.
        put_head(TAG_RIFF, TAG_WAVE);
        put_smpl(SMPL_MIN_SIZE, 1, 0, 0);
        send_file(file_bytes.size());
        // smpl chunk below its minimum size.
        put_head(TAG_RIFF, TAG_WAVE);
        put_smpl(SMPL_MIN_SIZE - 1, 1, 0, 0);
        send_file(file_bytes.size());
        // Chunk claims more bytes than the payload holds.
        put_head(TAG_RIFF, TAG_WAVE);
        put_chunk(32'h6174_6164, 32'hFFFF_FFFF, 4);
        send_file(file_bytes.size());
        // Wrong RIFF tag, then wrong WAVE tag.
        put_head(~TAG_RIFF, TAG_WAVE);
        put_noise(8);
        send_file(file_bytes.size());
        put_head(TAG_RIFF, ~TAG_WAVE);
        put_noise(8);
        send_file(file_bytes.size());
        // Declared length of zero on a single-word payload, then one short of a header.
        put_noise(1);
        send_file(0);
        put_noise(FILE_HDR_BYTES - 1);
        send_file(FILE_HDR_BYTES - 1);
        // Stream stops inside the file header.
        put_head(TAG_RIFF, TAG_WAVE);
        file_bytes = file_bytes[0:4];
        send_file(100);
        // Header alone fills the payload.
        put_head(TAG_RIFF, TAG_WAVE);
        send_file(file_bytes.size());
        // No smpl chunk and too few bytes left for another header.
        put_head(TAG_RIFF, TAG_WAVE);
        put_chunk(32'h5453_494C, 3, 3);
        put_noise(CHUNK_HDR_BYTES - 1);
        send_file(file_bytes.size());
        // Words past the declared length are ignored.
        put_head(TAG_RIFF, TAG_WAVE);
        put_smpl(SMPL_LOOP_SIZE, 1, 16, 32);
        mark = file_bytes.size();
        put_noise(20);
        send_file(mark);
        // Stream ends long before a maximal declared length.
        put_head(TAG_RIFF, TAG_WAVE);
        put_chunk(32'h2074_6D66, 2, 2);
        send_file(32'hFFFF_FFFF);

        // Three legs of random files: sender idling lightly, then heavily, then not at all.
        for (int leg = 0; leg < 3; leg++) begin
            valid_idle_pct = (leg == 0) ? 6 : ((leg == 1) ? 51 : 0);
            ready_idle_pct = (leg == 0) ? 51 : ((leg == 1) ? 6 : 0);
            words_sent = 0;
            files_sent = 0;
            while (words_sent < 190 || files_sent < 2) begin
                random_file();
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline latency.
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
